[hdl/assert_macros.svh]
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");

`endif

[hdl/iss_pkg.sv]
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants of the indexed sequence store: sizes, operation
// and status codes, memory access and result words.
// ----------------------------------------------------------------------------
package iss_pkg;

   localparam int CAPACITY   = 64;
   localparam int VALUE_BITS = 32;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);
   localparam int OP_W       = 3;
   localparam int POS_W      = 6;
   localparam int STATUS_W   = 2;

   typedef logic signed [VALUE_BITS-1:0] entry_type;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND   = 3'd0,
      OP_READ     = 3'd1,
      OP_REM_HEAD = 3'd2,
      OP_REM_TAIL = 3'd3,
      OP_REM_AT   = 3'd4,
      OP_REM_MID  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_RDWAIT,
      S_SHIFT,
      S_DONE
   } state_type;

   // one write port and one read port of the entry memory
   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      entry_type        wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } mem_req_type;

   // finished result handed to the output register
   typedef struct packed {
      entry_type        read_value;
      logic [CNT_W-1:0] entry_count;
      status_type       status;
   } result_type;

endpackage

[hdl/iss_mem.sv]
// ----------------------------------------------------------------------------
// iss_mem
// Entry memory: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module iss_mem (
   input  logic                 clock,
   input  iss_pkg::mem_req_type mem_req,
   output iss_pkg::entry_type   rd_data
);
   import iss_pkg::*;

   entry_type mem_ff [CAPACITY];

   // write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem_ff[mem_req.waddr] <= mem_req.wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data <= mem_ff[mem_req.raddr];
      end
   end

endmodule

[hdl/iss_ctrl.sv]
// ----------------------------------------------------------------------------
// iss_ctrl
// Request sequencer: decodes one request, drives the entry memory, walks
// the compaction loop after a removal and builds the result word.
// ----------------------------------------------------------------------------
module iss_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [iss_pkg::OP_W-1:0]          req_operation,
   input  logic signed [iss_pkg::VALUE_BITS-1:0] req_value,
   input  logic [iss_pkg::POS_W-1:0]         req_position,
   output iss_pkg::mem_req_type              mem_req,
   input  iss_pkg::entry_type                mem_rd_data,
   input  logic                              slot_free,
   output logic                              result_load,
   output iss_pkg::result_type               result
);
   import iss_pkg::*;

   state_type        state_ff, state_in;
   op_type           op_ff, op_in;
   entry_type        value_ff, value_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   entry_type        res_value_ff, res_value_in;
   status_type       res_status_ff, res_status_in;

   logic [CNT_W-1:0] del_idx;
   logic             del_ok;

   // index of the entry to delete (left zero for tail removal, which needs no shift) and whether it exists
   always_comb begin
      del_idx = '0;
      del_ok  = 1'b0;
      case (op_ff) inside
         OP_REM_HEAD, OP_REM_TAIL: begin
            del_idx = '0;
            del_ok  = (count_ff != '0);
         end
         OP_REM_AT: begin
            del_idx = {1'b0, pos_ff};
            del_ok  = ({1'b0, pos_ff} < count_ff);
         end
         OP_REM_MID: begin
            del_idx = ((count_ff + CNT_W'(1)) >> 1) - CNT_W'(1);
            del_ok  = (count_ff != '0);
         end
         default: begin
            del_idx = '0;
            del_ok  = 1'b0;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      value_ff      <= value_in;
      pos_ff        <= pos_in;
      wr_ptr_ff     <= wr_ptr_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
   end

   // next state and memory control
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      value_in      = value_ff;
      pos_in        = pos_ff;
      count_in      = count_ff;
      wr_ptr_in     = wr_ptr_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      mem_req       = '0;
      req_ready     = 1'b0;
      result_load   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = op_type'(req_operation);
               value_in = req_value;
               pos_in   = req_position;
               state_in = S_EXEC;
            end
         end

         S_EXEC: begin
            res_value_in  = '0;
            res_status_in = ST_DONE;
            state_in      = S_DONE;
            unique case (op_ff) inside
               OP_APPEND: begin
                  if (count_ff < CNT_W'(CAPACITY)) begin
                     mem_req.we    = 1'b1;
                     mem_req.waddr = count_ff[IDX_W-1:0];
                     mem_req.wdata = value_ff;
                     count_in      = count_ff + CNT_W'(1);
                  end else begin
                     res_status_in = ST_FULL;
                  end
               end
               OP_READ: begin
                  if ({1'b0, pos_ff} < count_ff) begin
                     mem_req.re    = 1'b1;
                     mem_req.raddr = pos_ff[IDX_W-1:0];
                     state_in      = S_RDWAIT;
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               OP_REM_TAIL: begin
                  if (del_ok) begin
                     count_in = count_ff - CNT_W'(1);
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               OP_REM_HEAD, OP_REM_AT, OP_REM_MID: begin
                  if (del_ok) begin
                     count_in = count_ff - CNT_W'(1);
                     // entries above the hole move down one place
                     if (del_idx < count_ff - CNT_W'(1)) begin
                        mem_req.re    = 1'b1;
                        mem_req.raddr = IDX_W'(del_idx + CNT_W'(1));
                        wr_ptr_in     = del_idx[IDX_W-1:0];
                        state_in      = S_SHIFT;
                     end
                  end else begin
                     res_status_in = ST_RANGE;
                  end
               end
               default: begin
                  res_status_in = ST_RANGE;
               end
            endcase
         end

         S_RDWAIT: begin
            res_value_in = mem_rd_data;
            state_in     = S_DONE;
         end

         // one entry moved per cycle, next read overlapped with this write
         S_SHIFT: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = wr_ptr_ff;
            mem_req.wdata = mem_rd_data;
            if ({1'b0, wr_ptr_ff} == count_ff - CNT_W'(1)) begin
               state_in = S_DONE;
            end else begin
               mem_req.re    = 1'b1;
               mem_req.raddr = wr_ptr_ff + IDX_W'(2);
               wr_ptr_in     = wr_ptr_ff + IDX_W'(1);
            end
         end

         S_DONE: begin
            if (slot_free) begin
               result_load = 1'b1;
               state_in    = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign result.read_value  = res_value_ff;
   assign result.entry_count = count_ff;
   assign result.status      = res_status_ff;

endmodule

[hdl/indexed_sequence_store_unit.sv]
// ----------------------------------------------------------------------------
// indexed_sequence_store_unit
// Ordered list of up to 64 signed words held compacted in a memory, with
// append, read, and head, tail, indexed and middle removal.
// ----------------------------------------------------------------------------
// Usage: a request word (operation, value, position) enters on req_valid /
// req_ready; exactly one response word (read_value, entry_count, status)
// leaves on rsp_valid / rsp_ready for every request, in order.
// Requests are handled one at a time. Append, tail removal and any rejected
// request pass from acceptance through the execute and done states to the
// response; a read passes through a read-wait state as well. Head,
// indexed and middle removal move every entry above the hole down one
// place, one entry per cycle through the single memory read/write port
// pair. The next request is taken the cycle after the response is loaded.
// A response waiting in the output register does not block the sequencer;
// if the receiver stalls and a second response is ready, the sequencer
// holds it and stops taking requests until the register frees.
// Reset clears the entry count and returns the sequencer to idle; no
// memory clearing pass is needed since only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_sequence_store_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [iss_pkg::OP_W-1:0]               req_operation,
   input  logic signed [iss_pkg::VALUE_BITS-1:0]  req_value,
   input  logic [iss_pkg::POS_W-1:0]              req_position,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [iss_pkg::VALUE_BITS-1:0]  rsp_read_value,
   output logic [iss_pkg::CNT_W-1:0]              rsp_entry_count,
   output logic [iss_pkg::STATUS_W-1:0]           rsp_status
);
   import iss_pkg::*;

   mem_req_type mem_req;
   entry_type   mem_rd_data;
   result_type  result;
   logic        result_load;
   logic        slot_free;

   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_word_ff;

   // entry memory
   iss_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (mem_rd_data)
   );

   // request sequencer
   iss_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .req_value     (req_value),
      .req_position  (req_position),
      .mem_req       (mem_req),
      .mem_rd_data   (mem_rd_data),
      .slot_free     (slot_free),
      .result_load   (result_load),
      .result        (result)
   );

   // output register
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_load) begin
         rsp_word_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_word_ff.read_value;
   assign rsp_entry_count = rsp_word_ff.entry_count;
   assign rsp_status      = rsp_word_ff.status;

   // checks
   `ASSERT_SAME(a_count_bound, clock, reset, rsp_valid,
      rsp_entry_count <= CNT_W'(CAPACITY))
   `ASSERT_SAME(a_full_count, clock, reset, rsp_valid && rsp_status == ST_FULL,
      rsp_entry_count == CNT_W'(CAPACITY))
   `ASSERT_SAME(a_value_zero, clock, reset, rsp_valid && rsp_status != ST_DONE,
      rsp_read_value == '0)
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready)

endmodule
